/* hw/rtl/rmr_pkg.sv */
// ----------------------------------------------------------------------------
// Room membership replicator package
// Table geometry, entry layout and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package rmr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] client;
        logic [31:0] room;
        logic [31:0] address;
        logic [15:0] port;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/rmr_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/room_membership_replicator.sv */
// ----------------------------------------------------------------------------
// Room membership replicator
// Keeps an ordered client table in RAM; a leave compacts it, a new source is
// appended, and a caster datagram fans out to the other members of its room.
// ----------------------------------------------------------------------------
// Operation: busy after start through one scan of the table
//   RAM, one entry read per cycle through its single registered read port.
// Results: one per cycle at most, the last one in the same cycle that busy falls.
// Datagrams: start is taken only while idle, so one datagram is handled at a time.
// Reset: synchronous; the table is empty after reset, entry RAM is not cleared.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module room_membership_replicator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_sender_id,
    input  logic [31:0] i_room_number,
    input  logic        i_from_caster,
    input  logic        i_leaving,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_source_port,
    output logic        o_dest_valid,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_dest_port,
    output logic        o_last_dest
);
    import rmr_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic             r_dv, n_dv;
    logic             r_found, n_found;
    logic             r_pend_vld, n_pend_vld;
    logic [31:0]      r_pend_addr, n_pend_addr;
    logic [15:0]      r_pend_port, n_pend_port;
    t_entry           r_item, n_item;
    logic             r_caster, n_caster;
    logic             r_leave, n_leave;
    logic             r_o_valid, n_o_valid;
    logic [31:0]      r_o_addr, n_o_addr;
    logic [15:0]      r_o_port, n_o_port;
    logic             r_o_last, n_o_last;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_q;

    rmr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd        <= n_rd;
        r_wr        <= n_wr;
        r_found     <= n_found;
        r_pend_vld  <= n_pend_vld;
        r_pend_addr <= n_pend_addr;
        r_pend_port <= n_pend_port;
        r_item      <= n_item;
        r_caster    <= n_caster;
        r_leave     <= n_leave;
        r_o_addr    <= n_o_addr;
        r_o_port    <= n_o_port;
        r_o_last    <= n_o_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_dv        = 1'b0;
        n_found     = r_found;
        n_pend_vld  = r_pend_vld;
        n_pend_addr = r_pend_addr;
        n_pend_port = r_pend_port;
        n_item      = r_item;
        n_caster    = r_caster;
        n_leave     = r_leave;
        n_o_valid   = 1'b0;
        n_o_addr    = r_o_addr;
        n_o_port    = r_o_port;
        n_o_last    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wr[IDX_W-1:0];
        ram_wdata   = ram_q;
        ram_raddr   = r_rd[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item.client  = i_sender_id;
                    n_item.room    = i_room_number;
                    n_item.address = i_source_address;
                    n_item.port    = i_source_port;
                    n_caster       = i_from_caster;
                    n_leave        = i_leaving;
                    n_rd           = '0;
                    n_wr           = '0;
                    n_found        = 1'b0;
                    n_pend_vld     = 1'b0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue next read
                if (r_rd < r_count) begin
                    n_rd = r_rd + 1'b1;
                    n_dv = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
                // process the entry read last cycle
                if (r_dv) begin
                    if (r_leave) begin
                        if (ram_q.client != r_item.client) begin
                            ram_we = 1'b1;
                            n_wr   = r_wr + 1'b1;
                        end
                    end else begin
                        if (ram_q.address == r_item.address && ram_q.port == r_item.port) begin
                            n_found = 1'b1;
                        end
                        if (r_caster && ram_q.room == r_item.room
                                && ram_q.client != r_item.client) begin
                            if (r_pend_vld) begin
                                n_o_valid = 1'b1;
                                n_o_addr  = r_pend_addr;
                                n_o_port  = r_pend_port;
                            end
                            n_pend_vld  = 1'b1;
                            n_pend_addr = ram_q.address;
                            n_pend_port = ram_q.port;
                        end
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                if (r_leave) begin
                    n_count = r_wr;
                end else begin
                    if (!r_found && r_count < CNT_W'(TABLE_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[IDX_W-1:0];
                        ram_wdata = r_item;
                        n_count   = r_count + 1'b1;
                    end
                    if (r_pend_vld) begin
                        n_o_valid = 1'b1;
                        n_o_addr  = r_pend_addr;
                        n_o_port  = r_pend_port;
                        n_o_last  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_dest_valid   = r_o_valid;
    assign o_dest_address = r_o_addr;
    assign o_dest_port    = r_o_port;
    assign o_last_dest    = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $past(r_state == S_SCAN || r_state == S_DONE))
        else $error("result without a datagram in progress");

    a_leave_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_leave) |=> !r_o_valid)
        else $error("leave datagram produced a result");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_dv && r_leave) |-> r_wr < r_rd)
        else $error("compaction write overtook the read pointer");

endmodule
